// File: hw/rtl/front_stack_with_search_delete_defines.svh
// Assertion macros shared by the checker of the front stack with search and delete.
`ifndef FRONT_STACK_WITH_SEARCH_DELETE_DEFINES_SVH
`define FRONT_STACK_WITH_SEARCH_DELETE_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define FSSD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is high.
`define FSSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/fssd_pkg.sv
// Package with the constants, codes and word types of the front stack with search and delete.
`default_nettype none
package fssd_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_GET    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } cmd_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  read_value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } rsp_word_t;

  typedef struct packed {
    logic shift_down;
    logic shift_up;
    logic remove;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/fssd_cmd_if.sv
// Valid and ready channel that carries one command word.
`default_nettype none
interface fssd_cmd_if;
  import fssd_pkg::*;

  logic      valid;
  logic      ready;
  cmd_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/fssd_rsp_if.sv
// Valid and ready channel that carries one response word.
`default_nettype none
interface fssd_rsp_if;
  import fssd_pkg::*;

  logic      valid;
  logic      ready;
  rsp_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/fssd_cell.sv
// One storage cell of the shift chain, with its own key compare and first-hit link.
`default_nettype none
module fssd_cell #(
  parameter int DATA_WIDTH = fssd_pkg::DEF_DATA_WIDTH
) (
  input  wire                      clk,
  input  fssd_pkg::cell_ctl_t      ctl,
  input  wire                      live,
  input  wire     [DATA_WIDTH-1:0] key,
  input  wire     [DATA_WIDTH-1:0] from_prev,
  input  wire     [DATA_WIDTH-1:0] from_next,
  input  wire                      hit_in,
  output logic    [DATA_WIDTH-1:0] data,
  output logic                     hit_out
);
  import fssd_pkg::*;

  logic match;

  assign match   = live && (data == key);
  assign hit_out = hit_in || match;

  always_ff @(posedge clk) begin
    if (ctl.shift_down) begin
      data <= from_prev;
    end else if (ctl.shift_up || (ctl.remove && hit_out)) begin
      data <= from_next;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/fssd_out_buf.sv
// Two-deep response buffer that decouples the chain from a stalled consumer.
`default_nettype none
module fssd_out_buf (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  res_valid,
  input  fssd_pkg::rsp_word_t  res,
  output logic                 buf_ready,
  fssd_rsp_if.source           rsp
);
  import fssd_pkg::*;

  logic      head_valid;
  rsp_word_t head;
  logic      skid_valid;
  rsp_word_t skid;

  assign buf_ready = !skid_valid;
  assign rsp.valid = head_valid;
  assign rsp.data  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!head_valid || rsp.ready) begin
      if (skid_valid) begin
        head       <= skid;
        head_valid <= 1'b1;
        skid       <= res;
        skid_valid <= res_valid;
      end else begin
        head       <= res;
        head_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid       <= res;
      skid_valid <= 1'b1;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/front_stack_with_search_delete.sv
// Top level of the bounded front stack with indexed read and search and delete.
// The list is held in a row of CAPACITY cells, the front in cell 0. Every command word
// (push, pop, get, remove, clear) is carried out in the clock cycle in which it is taken,
// so one word is accepted per clock while cmd.ready is high; the whole operation,
// including the search for the first matching entry and the closing of the gap, is one
// move of the cell chain. The response word is registered in a two-deep output buffer,
// and cmd.ready falls only when both buffer places hold responses that are not yet taken.
// Stored words are DATA_WIDTH bits wide; pushed values and keys are cut or zero-extended
// to that width and read values are returned in the 32-bit field.
`default_nettype none
module front_stack_with_search_delete #(
  parameter int CAPACITY   = fssd_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = fssd_pkg::DEF_DATA_WIDTH
) (
  input  wire         clk,
  input  wire         rst,
  fssd_cmd_if.sink    cmd,
  fssd_rsp_if.source  rsp
);
  import fssd_pkg::*;

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (CW > INDEX_W) ? CW : INDEX_W;

  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic                  accept;
  logic                  buf_ready;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] rd;
  status_t               status;
  cell_ctl_t             ctl;
  cell_ctl_t             ctl_gated;
  rsp_word_t             res;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] prev_data [CAPACITY];
  logic [DATA_WIDTH-1:0] next_data [CAPACITY];
  logic                  live      [CAPACITY];
  logic                  hit       [CAPACITY+1];

  assign cmd.ready = buf_ready;
  assign accept    = cmd.valid && buf_ready;
  assign word      = DATA_WIDTH'(cmd.data.value);
  assign ctl_gated = accept ? ctl : '0;
  assign hit[0]    = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_chain
    assign live[i] = CW'(i) < count;

    if (i == 0) begin : g_front
      assign prev_data[i] = word;
    end else begin : g_inner
      assign prev_data[i] = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign next_data[i] = cell_data[i];
    end else begin : g_link
      assign next_data[i] = cell_data[i+1];
    end

    fssd_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl_gated),
      .live      (live[i]),
      .key       (word),
      .from_prev (prev_data[i]),
      .from_next (next_data[i]),
      .hit_in    (hit[i]),
      .data      (cell_data[i]),
      .hit_out   (hit[i+1])
    );
  end

  always_comb begin
    ctl        = '0;
    status     = ST_OK;
    rd         = '0;
    count_next = count;
    case (cmd.data.kind)
      OP_PUSH: begin
        if (count == CW'(CAPACITY)) begin
          status = ST_FULL;
        end else begin
          ctl.shift_down = 1'b1;
          count_next     = CW'(count + 1'b1);
        end
      end
      OP_POP: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else begin
          rd           = cell_data[0];
          ctl.shift_up = 1'b1;
          count_next   = CW'(count - 1'b1);
        end
      end
      OP_GET: begin
        if (CMP_W'(cmd.data.index) >= CMP_W'(count)) begin
          status = ST_BAD_INDEX;
        end else begin
          rd = cell_data[AW'(cmd.data.index)];
        end
      end
      OP_REMOVE: begin
        ctl.remove = 1'b1;
        if (hit[CAPACITY]) begin
          count_next = CW'(count - 1'b1);
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  assign res.read_value = VALUE_W'(rd);
  assign res.status     = status;
  assign res.count      = COUNT_W'(count_next);

  fssd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (accept),
    .res       (res),
    .buf_ready (buf_ready),
    .rsp       (rsp)
  );
endmodule
`default_nettype wire

// File: hw/rtl/fssd_checker.sv
// Port-level checker for the front stack with search and delete, bound to the top level.
`default_nettype none
`include "front_stack_with_search_delete_defines.svh"
module fssd_checker #(
  parameter int CAPACITY = fssd_pkg::DEF_CAPACITY
) (
  input wire                          clk,
  input wire                          rst,
  input wire                          cmd_valid,
  input wire                          cmd_ready,
  input wire                          rsp_valid,
  input wire                          rsp_ready,
  input wire [fssd_pkg::VALUE_W-1:0]  rsp_read_value,
  input wire [fssd_pkg::STATUS_W-1:0] rsp_status,
  input wire [fssd_pkg::COUNT_W-1:0]  rsp_count
);
  import fssd_pkg::*;

  `FSSD_ASSERT_ALWAYS(a_reset_clears_rsp, clk, rst |=> !rsp_valid,
    "Response valid after reset")
  `FSSD_ASSERT(a_rsp_needs_cmd, clk, rst,
    $rose(rsp_valid) |-> $past(cmd_valid && cmd_ready),
    "Response word without an accepted command")
  `FSSD_ASSERT(a_fail_reads_zero, clk, rst,
    (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_read_value == '0),
    "Failed operation returned a data word")
  `FSSD_ASSERT(a_full_count, clk, rst,
    (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_count == COUNT_W'(CAPACITY)),
    "Full status with a count below capacity")
  `FSSD_ASSERT(a_rsp_held, clk, rst,
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_value) &&
      $stable(rsp_status) && $stable(rsp_count)),
    "Response word changed while stalled")
endmodule

bind front_stack_with_search_delete fssd_checker #(
  .CAPACITY(CAPACITY)
) u_fssd_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_read_value (rsp.data.read_value),
  .rsp_status     (rsp.data.status),
  .rsp_count      (rsp.data.count)
);
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the bounded front stack with indexed read and search and delete.
`default_nettype none
module testbench;
  import fssd_pkg::*;

  localparam logic [KIND_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int POOL_DEPTH   = 24;
  localparam int BURST_LEN    = 48;
  localparam int PHASE_WORDS  = 600;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    int                 reps;
    bit                 pinned;
    rsp_word_t          rsp;
  } stim_row_t;

  logic clk;
  logic rst;

  fssd_cmd_if cmd_ch ();
  fssd_rsp_if rsp_ch ();

  front_stack_with_search_delete u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  logic [VALUE_W-1:0] list_words [DEF_CAPACITY];
  int                 list_len = 0;
  rsp_word_t          pending_rsp [$];
  logic [VALUE_W-1:0] key_pool [$];
  stim_row_t          stim_table [$];
  bit                 pinned_on;
  rsp_word_t          pinned_rsp;
  int                 send_gap_pct;
  int                 stall_pct;
  int                 mismatches = 0;
  int                 kind_seen [8];
  int                 status_seen [8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Timeout with %0d responses outstanding.", pending_rsp.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic rsp_word_t apply_op(cmd_word_t c);
    rsp_word_t r;
    int        hit;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    case (c.kind)
      OP_PUSH: begin
        if (list_len >= DEF_CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int k = list_len; k > 0; k--) list_words[k] = list_words[k-1];
          list_words[0] = c.value;
          list_len++;
        end
      end
      OP_POP: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_value = list_words[0];
          for (int k = 0; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
          list_len--;
        end
      end
      OP_GET: begin
        if (int'(c.index) >= list_len) r.status = ST_BAD_INDEX;
        else r.read_value = list_words[c.index];
      end
      OP_REMOVE: begin
        for (int k = 0; k < list_len; k++) begin
          if (hit < 0 && list_words[k] == c.value) hit = k;
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int k = hit; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
          list_len--;
        end
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    r.count = COUNT_W'(list_len);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                 logic [VALUE_W-1:0] want);
    $display("Mismatch at %0t: %s is %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    rsp_word_t want;
    rsp_word_t got;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        want = apply_op(cmd_ch.data);
        if (pinned_on) want = pinned_rsp;
        pending_rsp.push_back(want);
        kind_seen[cmd_ch.data.kind]++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected response word", got.read_value, '0);
        end else begin
          want = pending_rsp.pop_front();
          status_seen[want.status]++;
          if (got.read_value !== want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
          if (got.status !== want.status)
            report_mismatch("status", VALUE_W'(got.status), VALUE_W'(want.status));
          if (got.count !== want.count)
            report_mismatch("count", VALUE_W'(got.count), VALUE_W'(want.count));
        end
      end
    end
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void add_row(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value,
                                  logic [INDEX_W-1:0] index, int reps, bit pinned,
                                  logic [VALUE_W-1:0] read_value, status_t status,
                                  int count);
    stim_row_t row;
    row.kind = kind;
    row.value = value;
    row.index = index;
    row.reps = reps;
    row.pinned = pinned;
    row.rsp.read_value = read_value;
    row.rsp.status = status;
    row.rsp.count = COUNT_W'(count);
    stim_table.push_back(row);
  endfunction

  // The next word replaces the one just taken in the same step; valid drops only during a random send gap.
  task automatic send_word(cmd_word_t w, bit pin, rsp_word_t pin_rsp);
    while ($urandom_range(99) < send_gap_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= w;
    pinned_on <= pin;
    pinned_rsp <= pin_rsp;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  function automatic cmd_word_t make_random_word(int push_pct);
    cmd_word_t w;
    int        sel;
    w.kind = OP_GET;
    w.value = $urandom();
    w.index = INDEX_W'($urandom_range(15));
    sel = $urandom_range(99);
    if (sel < 2) begin
      w.kind = OP_CLEAR;
    end else if (sel < 4) begin
      w.kind = KIND_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end else if ($urandom_range(99) < push_pct) begin
      w.kind = OP_PUSH;
      sel = $urandom_range(9);
      if (sel < 3) w.value = $urandom_range(7);
      else if (sel < 5 && key_pool.size() > 0)
        w.value = key_pool[$urandom_range(key_pool.size() - 1)];
      key_pool.push_back(w.value);
      if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
    end else begin
      case ($urandom_range(2))
        0: w.kind = OP_POP;
        1: w.kind = OP_GET;
        default: begin
          w.kind = OP_REMOVE;
          sel = $urandom_range(9);
          if (sel < 7 && key_pool.size() > 0)
            w.value = key_pool[$urandom_range(key_pool.size() - 1)];
          else if (sel < 8) w.value = $urandom_range(7);
        end
      endcase
    end
    return w;
  endfunction

  initial begin
    cmd_word_t w;
    int        push_pct;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    pinned_on = 1'b0;
    pinned_rsp = '0;
    send_gap_pct = 28;
    stall_pct = 55;
    push_pct = 50;
    foreach (list_words[k]) list_words[k] = '0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    foreach (status_seen[k]) status_seen[k] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    add_row(OP_POP, 32'h0, 4'h0, 1, 1, 32'h0, ST_EMPTY, 0);
    add_row(OP_GET, 32'h0, 4'h0, 1, 1, 32'h0, ST_BAD_INDEX, 0);
    add_row(OP_REMOVE, 32'h5, 4'h0, 1, 1, 32'h0, ST_NOT_FOUND, 0);
    add_row(OP_PUSH, 32'h0, 4'h0, 1, 1, 32'h0, ST_OK, 1);
    add_row(OP_PUSH, 32'hFFFF_FFFF, 4'h0, 1, 1, 32'h0, ST_OK, 2);
    add_row(OP_GET, 32'h0, 4'h0, 1, 1, 32'hFFFF_FFFF, ST_OK, 2);
    add_row(OP_GET, 32'h0, 4'h2, 1, 1, 32'h0, ST_BAD_INDEX, 2);
    add_row(OP_SPARE_LO, 32'h1234_5678, 4'h9, 1, 1, 32'h0, ST_OK, 2);
    add_row(OP_SPARE_HI, 32'hFFFF_FFFF, 4'hF, 1, 1, 32'h0, ST_OK, 2);
    add_row(OP_REMOVE, 32'h0, 4'h0, 1, 1, 32'h0, ST_OK, 1);
    add_row(OP_PUSH, 32'h5A00_0000, 4'h0, 14, 0, 32'h0, ST_OK, 0);
    add_row(OP_PUSH, 32'hFFFF_FFFF, 4'h0, 1, 1, 32'h0, ST_OK, 16);
    add_row(OP_PUSH, 32'h1, 4'h0, 1, 1, 32'h0, ST_FULL, 16);
    add_row(OP_GET, 32'h0, 4'hF, 1, 1, 32'hFFFF_FFFF, ST_OK, 16);
    add_row(OP_REMOVE, 32'hFFFF_FFFF, 4'h0, 1, 0, 32'h0, ST_OK, 0);
    add_row(OP_GET, 32'h0, 4'hE, 1, 0, 32'h0, ST_OK, 0);
    add_row(OP_REMOVE, 32'h1234_5678, 4'h0, 1, 1, 32'h0, ST_NOT_FOUND, 15);
    add_row(OP_POP, 32'h0, 4'h0, 1, 0, 32'h0, ST_OK, 0);
    add_row(OP_GET, 32'h0, 4'h0, 1, 0, 32'h0, ST_OK, 0);
    add_row(OP_CLEAR, 32'h0, 4'h0, 1, 1, 32'h0, ST_OK, 0);
    add_row(OP_POP, 32'h0, 4'h0, 1, 1, 32'h0, ST_EMPTY, 0);

    foreach (stim_table[r]) begin
      for (int n = 0; n < stim_table[r].reps; n++) begin
        w.kind = stim_table[r].kind;
        w.value = stim_table[r].value + n;
        w.index = stim_table[r].index;
        send_word(w, stim_table[r].pinned, stim_table[r].rsp);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct = (phase == 0) ? 28 : (phase == 1) ? 55 : 0;
      stall_pct = (phase == 0) ? 55 : (phase == 1) ? 28 : 0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Bursts that lean to pushes fill the list; bursts that lean away drain it.
        if (n % BURST_LEN == 0) begin
          case ($urandom_range(2))
            0: push_pct = 15;
            1: push_pct = 50;
            default: push_pct = 85;
          endcase
        end
        send_word(make_random_word(push_pct), 1'b0, '0);
      end
    end
    cmd_ch.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d push, %0d pop, %0d get, %0d remove, %0d clear, %0d spare-code words.",
             kind_seen[OP_PUSH], kind_seen[OP_POP], kind_seen[OP_GET], kind_seen[OP_REMOVE],
             kind_seen[OP_CLEAR], kind_seen[5] + kind_seen[6] + kind_seen[7]);
    $display("Responses: %0d ok, %0d empty, %0d full, %0d bad index, %0d not found.",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
             status_seen[ST_BAD_INDEX], status_seen[ST_NOT_FOUND]);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
+incdir+hw/rtl
hw/rtl/fssd_pkg.sv
hw/rtl/fssd_cmd_if.sv
hw/rtl/fssd_rsp_if.sv
hw/rtl/fssd_cell.sv
hw/rtl/fssd_out_buf.sv
hw/rtl/front_stack_with_search_delete.sv
hw/rtl/fssd_checker.sv
sim/testbench.sv
